// ===== rtl/stq_pkg.sv =====
package stq_pkg;

   localparam int TIME_WIDTH   = 32;
   localparam int HANDLE_WIDTH = 16;

   localparam int SEC_PER_HOUR     = 3600;
   localparam int SEC_PER_MINUTE   = 60;
   localparam int MAX_HOUR         = 23;
   localparam int MAX_MINUTE       = 59;
   localparam int HOURS_PER_DAY    = 24;
   localparam int MINUTES_PER_HOUR = 60;
   localparam int PM_OFFSET        = 12;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_EXPIRE = 2'd2;
   localparam logic [1:0] CMD_LIST   = 2'd3;

   localparam logic [1:0] MER_NONE = 2'd0;
   localparam logic [1:0] MER_PM   = 2'd2;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_EMPTY    = 3'd1;
   localparam logic [2:0] STAT_BAD_POS  = 3'd2;
   localparam logic [2:0] STAT_NO_EVENT = 3'd3;
   localparam logic [2:0] STAT_BAD_TIME = 3'd4;
   localparam logic [2:0] STAT_REL_MER  = 3'd5;
   localparam logic [2:0] STAT_FULL     = 3'd6;

   typedef struct packed {
      logic [1:0]            command;
      logic [6:0]            hours;
      logic [6:0]            minutes;
      logic                  relative;
      logic [1:0]            meridian;
      logic [TIME_WIDTH-1:0] now_seconds;
      logic [4:0]            now_hour;
      logic [5:0]            now_minute;
      logic [5:0]            now_second;
      logic [HANDLE_WIDTH-1:0] event_handle;
      logic [7:0]            position;
   } req_item_type;

   typedef struct packed {
      logic [2:0]              status;
      logic                    event_valid;
      logic [HANDLE_WIDTH-1:0] out_handle;
      logic [TIME_WIDTH-1:0]   out_due;
      logic [4:0]              out_index;
      logic                    last;
      logic [4:0]              queue_count;
      logic                    next_valid;
      logic [TIME_WIDTH-1:0]   next_due;
   } rsp_item_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]   due;
      logic [HANDLE_WIDTH-1:0] handle;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_PULL
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occupied;
   } cell_ctl_type;

   typedef struct packed {
      logic le;
      logic lt;
   } cell_flags_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_PULL,
      CHAIN_REMOVE
   } chain_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_ADD,
      ST_REMOVE,
      ST_EXP_PREP,
      ST_EXP_RUN,
      ST_LIST,
      ST_NOTE
   } state_type;

endpackage

// ===== rtl/stq_cell.sv =====
module stq_cell
   import stq_pkg::*;
(
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [TIME_WIDTH-1:0] key,
   input  entry_type             new_entry,
   input  entry_type             left_entry,
   input  logic                  left_le,
   input  entry_type             right_entry,
   output entry_type             entry,
   output cell_flags_type        flags
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry    = entry_ff;
   assign flags.le = ctl.occupied & (entry_ff.due <= key);
   assign flags.lt = ctl.occupied & (entry_ff.due < key);

   // On insert, cells at or before the new time keep their entry, the first
   // later cell takes the new entry and the rest take their left neighbor.
   always_comb begin
      case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (flags.le) begin
               entry_in = entry_ff;
            end else if (left_le) begin
               entry_in = new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         CELL_PULL: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/stq_due_calc.sv =====
module stq_due_calc
   import stq_pkg::*;
(
   input  req_item_type          req,
   input  logic                  full,
   output logic [2:0]            status,
   output logic [TIME_WIDTH-1:0] due
);

   localparam logic signed [8:0]  PM_S       = 9'(PM_OFFSET);
   localparam logic signed [8:0]  DAY_S      = 9'(HOURS_PER_DAY);
   localparam logic signed [8:0]  HOUR_MIN_S = 9'(MINUTES_PER_HOUR);
   localparam logic signed [8:0]  LAST_HR_S  = 9'(MAX_HOUR);
   localparam logic signed [20:0] HOUR_SEC_S = 21'(SEC_PER_HOUR);
   localparam logic signed [16:0] MIN_SEC_S  = 17'(SEC_PER_MINUTE);

   logic signed [8:0]  hr_adj;
   logic signed [8:0]  dh0;
   logic signed [8:0]  dh1;
   logic signed [8:0]  dm0;
   logic signed [8:0]  dh;
   logic signed [8:0]  dm;
   logic signed [20:0] dh_sec;
   logic signed [16:0] dm_sec;

   always_comb begin
      hr_adj = $signed({2'b00, req.hours}) + ((req.meridian == MER_PM) ? PM_S : 9'sd0);
      dh0    = hr_adj - $signed({4'b0000, req.now_hour});
      dh1    = (dh0 < 0) ? dh0 + DAY_S : dh0;
      dm0    = $signed({2'b00, req.minutes}) - $signed({3'b000, req.now_minute});
      if (req.relative) begin
         dh = hr_adj;
         dm = $signed({2'b00, req.minutes});
      end else if (dm0 < 0) begin
         // Borrow an hour; going below zero lands on the last hour of the day.
         dm = dm0 + HOUR_MIN_S;
         dh = dh1 - 9'sd1;
         if (dh < 0) begin
            dh = LAST_HR_S;
         end
      end else begin
         dh = dh1;
         dm = dm0;
      end
   end

   assign dh_sec = 21'(dh) * HOUR_SEC_S;
   assign dm_sec = 17'(dm) * MIN_SEC_S;

   assign due = req.now_seconds - TIME_WIDTH'(req.now_second)
              + TIME_WIDTH'(dh_sec) + TIME_WIDTH'(dm_sec);

   always_comb begin
      if ((req.hours > 7'(MAX_HOUR)) || (req.minutes > 7'(MAX_MINUTE))) begin
         status = STAT_BAD_TIME;
      end else if ((req.meridian != MER_NONE) && req.relative) begin
         status = STAT_REL_MER;
      end else if (full) begin
         status = STAT_FULL;
      end else begin
         status = STAT_OK;
      end
   end

endmodule

// ===== rtl/sorted_timer_event_queue_core.sv =====
// Handles one item at a time; req_stall is high from acceptance until the item is done.
// Add computes the due time in ST_CALC, then inserts in ST_ADD; remove runs in ST_REMOVE.
// Expire counts due entries, then pops one per result, or answers via ST_NOTE if none is due.
// List rotates the whole chain once, or answers via ST_NOTE when empty.
// A waiting result stalled downstream holds each step that would emit a result.
// Reset empties the queue and clears the control state; the cell contents are not cleared.
module sorted_timer_event_queue_core
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int IW   = $clog2(QUEUE_DEPTH);
   localparam int CMPW = (CW > 8) ? CW : 8;

   state_type             state_ff, state_in;
   req_item_type          req_ff, req_in;
   logic [TIME_WIDTH-1:0] add_due_ff, add_due_in;
   logic [2:0]            add_status_ff, add_status_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TIME_WIDTH-1:0] head_ff, head_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic [IW-1:0]         step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   chain_mode_type        chain_mode;
   entry_type             cell_q [QUEUE_DEPTH];
   cell_flags_type        cell_f [QUEUE_DEPTH];
   cell_ctl_type          cell_c [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0] key;
   entry_type             new_entry;

   logic [2:0]            calc_status;
   logic [TIME_WIDTH-1:0] calc_due;
   logic                  count_full;
   logic [2:0]            rem_status;
   logic [CW-1:0]         exp_k;
   logic [TIME_WIDTH-1:0] exp_head;
   logic                  out_free;
   logic                  req_accept;
   logic                  list_emit;
   logic                  emit;
   rsp_item_type          emit_item;
   logic [TIME_WIDTH-1:0] res_head;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   assign count_full = (count_ff == CW'(QUEUE_DEPTH));
   assign new_entry  = '{due: add_due_ff, handle: req_ff.event_handle};
   assign key        = (state_ff == ST_ADD) ? add_due_ff : req_ff.now_seconds;
   assign list_emit  = (CW'(step_ff) < count_ff);

   stq_due_calc u_due_calc (
      .req    (req_ff),
      .full   (count_full),
      .status (calc_status),
      .due    (calc_due)
   );

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      cell_op_type op;
      logic        pull_here;
      entry_type   left_entry;
      entry_type   right_entry;
      logic        left_le;

      assign pull_here = (CMPW'(g + 1) >= CMPW'(req_ff.position));

      always_comb begin
         case (chain_mode)
            CHAIN_HOLD:   op = CELL_HOLD;
            CHAIN_INSERT: op = CELL_INSERT;
            CHAIN_PULL:   op = CELL_PULL;
            CHAIN_REMOVE: op = pull_here ? CELL_PULL : CELL_HOLD;
            default:      op = CELL_HOLD;
         endcase
      end

      assign cell_c[g] = '{op: op, occupied: (CW'(g) < count_ff)};

      if (g == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_le    = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_q[g-1];
         assign left_le    = cell_f[g-1].le;
      end

      // The last cell pulls from the first so that a full pass rotates the chain.
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_q[0];
      end else begin : g_body
         assign right_entry = cell_q[g+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_c[g]),
         .key         (key),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_le     (left_le),
         .right_entry (right_entry),
         .entry       (cell_q[g]),
         .flags       (cell_f[g])
      );
   end

   // Entries due before now form a prefix, so its end marks both the pop count
   // and the entry that becomes the head.
   always_comb begin
      logic prev_lt;
      logic bnd;
      exp_k    = '0;
      exp_head = '0;
      prev_lt  = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         bnd     = prev_lt & ~cell_f[i].lt;
         prev_lt = cell_f[i].lt;
         if (bnd) begin
            exp_k = exp_k | CW'(i);
         end
         if (bnd & cell_c[i].occupied) begin
            exp_head = exp_head | cell_q[i].due;
         end
      end
      if (cell_f[QUEUE_DEPTH-1].lt) begin
         exp_k = CW'(QUEUE_DEPTH);
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         rem_status = STAT_EMPTY;
      end else if (req_ff.position == 8'd0) begin
         rem_status = STAT_BAD_POS;
      end else if (CMPW'(req_ff.position) > CMPW'(count_ff)) begin
         rem_status = STAT_NO_EVENT;
      end else begin
         rem_status = STAT_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      add_due_in    = add_due_ff;
      add_status_in = add_status_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      remain_in     = remain_ff;
      step_in       = step_ff;
      chain_mode    = CHAIN_HOLD;
      emit          = 1'b0;
      emit_item     = '0;
      res_head      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_item;
               case (req_item.command)
                  CMD_ADD:    state_in = ST_CALC;
                  CMD_REMOVE: state_in = ST_REMOVE;
                  CMD_EXPIRE: state_in = ST_EXP_PREP;
                  CMD_LIST: begin
                     head_in  = (count_ff != '0) ? cell_q[0].due : '0;
                     step_in  = '0;
                     state_in = (count_ff == '0) ? ST_NOTE : ST_LIST;
                  end
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CALC: begin
            add_due_in    = calc_due;
            add_status_in = calc_status;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_item.status = add_status_ff;
               emit_item.last   = 1'b1;
               res_head         = cell_q[0].due;
               if (add_status_ff == STAT_OK) begin
                  chain_mode = CHAIN_INSERT;
                  count_in   = count_ff + CW'(1);
                  res_head   = cell_f[0].le ? cell_q[0].due : add_due_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_REMOVE: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_item.status = rem_status;
               emit_item.last   = 1'b1;
               res_head         = cell_q[0].due;
               if (rem_status == STAT_OK) begin
                  chain_mode = CHAIN_REMOVE;
                  count_in   = count_ff - CW'(1);
                  res_head   = (req_ff.position == 8'd1) ? cell_q[1].due : cell_q[0].due;
               end
               state_in = ST_IDLE;
            end
         end
         ST_EXP_PREP: begin
            count_in  = count_ff - exp_k;
            head_in   = exp_head;
            remain_in = exp_k;
            state_in  = (exp_k == '0) ? ST_NOTE : ST_EXP_RUN;
         end
         ST_EXP_RUN: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_item.event_valid = 1'b1;
               emit_item.out_handle  = cell_q[0].handle;
               emit_item.out_due     = cell_q[0].due;
               emit_item.last        = (remain_ff == CW'(1));
               chain_mode            = CHAIN_PULL;
               remain_in             = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIST: begin
            if (list_emit & out_free) begin
               emit                  = 1'b1;
               emit_item.event_valid = 1'b1;
               emit_item.out_handle  = cell_q[0].handle;
               emit_item.out_due     = cell_q[0].due;
               emit_item.out_index   = 5'(CW'(step_ff) + CW'(1));
               emit_item.last        = (CW'(step_ff) == count_ff - CW'(1));
            end
            if (~list_emit | out_free) begin
               chain_mode = CHAIN_PULL;
               step_in    = step_ff + IW'(1);
               if (step_ff == IW'(QUEUE_DEPTH - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NOTE: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_item.last = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      emit_item.queue_count = 5'(count_in);
      emit_item.next_valid  = (count_in != '0);
      emit_item.next_due    = (count_in != '0) ? res_head : '0;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_item_in = emit ? emit_item : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      add_due_ff    <= add_due_in;
      add_status_ff <= add_status_in;
      head_ff       <= head_in;
      remain_ff     <= remain_in;
      step_ff       <= step_in;
      rsp_item_ff   <= rsp_item_in;
   end

endmodule

// ===== tb/sv/event_queue_checker.sv =====
`timescale 1ns / 1ps
module event_queue_checker
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   output int           failures,
   output int           outstanding
);

   logic [TIME_WIDTH-1:0]   slot_due [QUEUE_DEPTH];
   logic [HANDLE_WIDTH-1:0] slot_handle [QUEUE_DEPTH];
   int                      entries;
   rsp_item_type            awaited [$];

   // Closes the gap left by the entry at index p.
   task automatic drop_entry(input int p);
      int i;
      for (i = p; i + 1 < entries; i++) begin
         slot_due[i]    = slot_due[i + 1];
         slot_handle[i] = slot_handle[i + 1];
      end
      entries--;
   endtask

   task automatic apply_command(input req_item_type it);
      rsp_item_type          batch [$];
      rsp_item_type          r;
      logic [2:0]            st;
      int                    dh;
      int                    dm;
      int                    slot;
      int                    i;
      logic [TIME_WIDTH-1:0] due;
      r = '0;
      case (it.command)
         CMD_ADD: begin
            if (it.hours > MAX_HOUR || it.minutes > MAX_MINUTE) begin
               st = STAT_BAD_TIME;
            end else if (it.meridian != MER_NONE && it.relative) begin
               st = STAT_REL_MER;
            end else if (entries >= QUEUE_DEPTH) begin
               st = STAT_FULL;
            end else begin
               st = STAT_OK;
               dh = int'(it.hours) + ((it.meridian == MER_PM) ? PM_OFFSET : 0);
               dm = int'(it.minutes);
               if (!it.relative) begin
                  // Next occurrence of the clock time, counted from the current minute.
                  dh -= int'(it.now_hour);
                  if (dh < 0) dh += HOURS_PER_DAY;
                  dm -= int'(it.now_minute);
                  if (dm < 0) begin
                     dm += MINUTES_PER_HOUR;
                     dh -= 1;
                     if (dh < 0) dh = MAX_HOUR;
                  end
               end
               due = it.now_seconds - TIME_WIDTH'(it.now_second)
                     + TIME_WIDTH'(dh * SEC_PER_HOUR) + TIME_WIDTH'(dm * SEC_PER_MINUTE);
               // Equal due times keep their arrival order.
               slot = 0;
               while (slot < entries && slot_due[slot] <= due) slot++;
               for (i = entries; i > slot; i--) begin
                  slot_due[i]    = slot_due[i - 1];
                  slot_handle[i] = slot_handle[i - 1];
               end
               slot_due[slot]    = due;
               slot_handle[slot] = it.event_handle;
               entries++;
            end
            r.status = st;
            batch.push_back(r);
         end
         CMD_REMOVE: begin
            if (entries == 0) begin
               r.status = STAT_EMPTY;
            end else if (it.position == 0) begin
               r.status = STAT_BAD_POS;
            end else if (it.position > entries) begin
               r.status = STAT_NO_EVENT;
            end else begin
               r.status = STAT_OK;
               drop_entry(int'(it.position) - 1);
            end
            batch.push_back(r);
         end
         CMD_EXPIRE: begin
            while (entries > 0 && slot_due[0] < it.now_seconds) begin
               r             = '0;
               r.event_valid = 1'b1;
               r.out_handle  = slot_handle[0];
               r.out_due     = slot_due[0];
               batch.push_back(r);
               drop_entry(0);
            end
            if (batch.size() == 0) batch.push_back('0);
         end
         default: begin
            for (i = 0; i < entries; i++) begin
               r             = '0;
               r.event_valid = 1'b1;
               r.out_handle  = slot_handle[i];
               r.out_due     = slot_due[i];
               r.out_index   = 5'(i + 1);
               batch.push_back(r);
            end
            if (batch.size() == 0) batch.push_back('0);
         end
      endcase
      // Queue summary fields describe the state after the whole command.
      for (i = 0; i < batch.size(); i++) begin
         r             = batch[i];
         r.last        = (i == batch.size() - 1);
         r.queue_count = 5'(entries);
         r.next_valid  = (entries > 0);
         r.next_due    = (entries > 0) ? slot_due[0] : '0;
         awaited.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         entries = 0;
         awaited.delete();
      end else begin
         if (req_valid && !req_stall) apply_command(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result item arrived with no result pending");
               failures++;
            end else begin
               want = awaited.pop_front();
               compare_field("status", want.status, rsp_item.status);
               compare_field("event_valid", want.event_valid, rsp_item.event_valid);
               compare_field("out_handle", want.out_handle, rsp_item.out_handle);
               compare_field("out_due", want.out_due, rsp_item.out_due);
               compare_field("out_index", want.out_index, rsp_item.out_index);
               compare_field("last", want.last, rsp_item.last);
               compare_field("queue_count", want.queue_count, rsp_item.queue_count);
               compare_field("next_valid", want.next_valid, rsp_item.next_valid);
               compare_field("next_due", want.next_due, rsp_item.next_due);
            end
         end
      end
      outstanding = awaited.size();
   end

endmodule

// ===== tb/sv/sorted_timer_event_queue_core_tb.sv =====
`timescale 1ns / 1ps
module sorted_timer_event_queue_core_tb;
   import stq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 380;
   localparam int SEGMENT_LEN  = 40;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   rsp_item_type rsp_item;

   int                    failures;
   int                    outstanding;
   bit                    calm_send;
   bit                    calm_recv;
   logic [TIME_WIDTH-1:0] wall_now;

   sorted_timer_event_queue_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   event_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) queue_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int idle_cycles(input bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic req_item_type make_add(input logic [6:0] hours, input logic [6:0] minutes,
                                             input logic relative, input logic [1:0] meridian,
                                             input logic [TIME_WIDTH-1:0] now_s,
                                             input logic [4:0] now_h, input logic [5:0] now_m,
                                             input logic [5:0] now_sec,
                                             input logic [HANDLE_WIDTH-1:0] handle);
      req_item_type it;
      it              = '0;
      it.command      = CMD_ADD;
      it.hours        = hours;
      it.minutes      = minutes;
      it.relative     = relative;
      it.meridian     = meridian;
      it.now_seconds  = now_s;
      it.now_hour     = now_h;
      it.now_minute   = now_m;
      it.now_second   = now_sec;
      it.event_handle = handle;
      return it;
   endfunction

   function automatic req_item_type make_cmd(input logic [1:0] command,
                                             input logic [TIME_WIDTH-1:0] now_s,
                                             input logic [7:0] position);
      req_item_type it;
      it             = '0;
      it.command     = command;
      it.now_seconds = now_s;
      it.position    = position;
      return it;
   endfunction

   // Mode 0 fills the queue, mode 1 mixes commands, mode 2 drains it.
   function automatic req_item_type random_req(input int mode);
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      case (mode)
         0:       it.command = (pick < 85) ? CMD_ADD : (pick < 90) ? CMD_REMOVE :
                               (pick < 95) ? CMD_EXPIRE : CMD_LIST;
         1:       it.command = (pick < 45) ? CMD_ADD : (pick < 65) ? CMD_REMOVE :
                               (pick < 85) ? CMD_EXPIRE : CMD_LIST;
         default: it.command = (pick < 20) ? CMD_ADD : (pick < 50) ? CMD_REMOVE :
                               (pick < 80) ? CMD_EXPIRE : CMD_LIST;
      endcase
      it.hours    = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, MAX_HOUR));
      it.minutes  = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                : 7'($urandom_range(0, MAX_MINUTE));
      it.relative = 1'($urandom);
      if (it.relative)
         it.meridian = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : MER_NONE;
      else
         it.meridian = 2'($urandom);
      if ($urandom_range(0, 19) == 0)
         it.now_seconds = $urandom;
      else if (it.command == CMD_EXPIRE)
         it.now_seconds = wall_now + TIME_WIDTH'($urandom_range(0, 100000));
      else
         it.now_seconds = wall_now + TIME_WIDTH'($urandom_range(0, 600));
      it.now_hour     = ($urandom_range(0, 19) == 0) ? 5'($urandom)
                                                     : 5'($urandom_range(0, MAX_HOUR));
      it.now_minute   = ($urandom_range(0, 19) == 0) ? 6'($urandom)
                                                     : 6'($urandom_range(0, MAX_MINUTE));
      it.now_second   = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, 60));
      it.event_handle = HANDLE_WIDTH'($urandom);
      pick = $urandom_range(0, 9);
      it.position = (pick == 0) ? 8'd0 : (pick == 1) ? 8'($urandom)
                                       : 8'($urandom_range(1, QUEUE_DEPTH + 1));
      return it;
   endfunction

   // Holds valid through back-to-back items and returns on the falling edge after acceptance.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = idle_cycles(calm_send);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   initial begin
      int hold;
      forever begin
         hold = idle_cycles(calm_recv);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int mode;
      calm_send = 1'b0;
      calm_recv = 1'b0;
      wall_now  = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue behavior.
      send_item(make_cmd(CMD_LIST, '0, 8'd0));
      send_item(make_cmd(CMD_EXPIRE, '1, 8'd0));
      send_item(make_cmd(CMD_REMOVE, '0, 8'd1));
      // Range and suffix errors.
      send_item(make_add(7'd24, 7'd0, 1'b0, MER_NONE, 32'd1000, 5'd1, 6'd2, 6'd3, 16'h1111));
      send_item(make_add(7'h7f, 7'h7f, 1'b1, 2'd3, '1, 5'h1f, 6'h3f, 6'h3f, 16'hffff));
      send_item(make_add(7'd0, 7'd60, 1'b0, MER_NONE, 32'd1000, 5'd1, 6'd2, 6'd3, 16'h2222));
      send_item(make_add(7'd1, 7'd1, 1'b1, 2'd1, 32'd1000, 5'd1, 6'd2, 6'd3, 16'h3333));
      send_item(make_add(7'd1, 7'd1, 1'b1, 2'd3, 32'd1000, 5'd1, 6'd2, 6'd3, 16'h4444));
      // Relative adds at the extremes, one wrapping past the top of the time range.
      send_item(make_add(7'd23, 7'd59, 1'b1, MER_NONE, '1, 5'd0, 6'd0, 6'd60, 16'hffff));
      send_item(make_add(7'd0, 7'd0, 1'b1, MER_NONE, '0, 5'd0, 6'd0, 6'd0, 16'h0000));
      // Absolute adds: pm on the largest hour, am, the do-nothing suffix, minute borrow.
      send_item(make_add(7'd23, 7'd59, 1'b0, MER_PM, 32'h8000_0000, 5'd23, 6'd59, 6'd59,
                         16'h5555));
      send_item(make_add(7'd0, 7'd0, 1'b0, 2'd1, 32'h8000_0000, 5'd0, 6'd0, 6'd0, 16'h6666));
      send_item(make_add(7'd5, 7'd30, 1'b0, 2'd3, 32'h8000_0000, 5'h1f, 6'h3f, 6'h3f,
                         16'h7777));
      send_item(make_add(7'd0, 7'd0, 1'b0, MER_NONE, 32'h4000_0000, 5'd0, 6'd1, 6'd0,
                         16'h8888));
      // Same due time as an earlier entry goes behind it.
      send_item(make_add(7'd0, 7'd0, 1'b0, 2'd1, 32'h8000_0000, 5'd0, 6'd0, 6'd0, 16'h9999));
      send_item(make_cmd(CMD_REMOVE, '0, 8'd0));
      send_item(make_cmd(CMD_REMOVE, '0, 8'hff));
      send_item(make_cmd(CMD_LIST, '0, 8'd0));
      send_item(make_cmd(CMD_REMOVE, '0, 8'd2));
      send_item(make_cmd(CMD_EXPIRE, '0, 8'd0));
      send_item(make_cmd(CMD_EXPIRE, 32'h8000_0000, 8'd0));
      send_item(make_cmd(CMD_LIST, '0, 8'd0));
      send_item(make_cmd(CMD_EXPIRE, '1, 8'd0));
      send_item(make_cmd(CMD_LIST, '0, 8'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            mode      = (n / SEGMENT_LEN) % 3;
            calm_send = ($urandom_range(0, 3) == 0);
            calm_recv = ($urandom_range(0, 3) == 0);
         end
         wall_now += TIME_WIDTH'($urandom_range(0, 2000));
         send_item(random_req(mode));
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
